// ===== design/lcs_pkg.sv =====
// Shared types and constants for the linear contrast stretch unit.
// No dependencies; used by lcs_ctrl, lcs_datapath and the top level.
`default_nettype none

package lcs_pkg;

	// Frame store depth and derived widths
	localparam int MAX_PIXELS = 4096;
	localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int PIX_W      = 8;
	localparam int QUO_BITS   = PIX_W;
	localparam int STEP_W     = $clog2(QUO_BITS);

	// Item operation codes
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic mem_rd;
		logic prep;
		logic div_step;
		logic finish;
	} lcs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic count_zero;
		logic div_last;
		logic out_busy;
	} lcs_stat_t;

endpackage

`default_nettype wire

// ===== design/linear_contrast_stretch_unit.sv =====
// Linear contrast stretch unit: one input channel carries load and drain items,
// one output channel carries stretched pixels. A drain of a non-empty store steps
// through a frame store read, a setup step, the restoring divider (one quotient
// bit per cycle, eight quotient bits) and a hand-off of the result to the output
// register; the hand-off waits while a previous output beat is still stalled.
// Loads after draining has begun are ignored, loads past the store depth are
// dropped and flagged, and a drain of an empty store gives no beat. The store and
// trackers clear when the last pixel of a frame is drained.
// Depends on lcs_pkg, lcs_ctrl and lcs_datapath.
`default_nettype none

module linear_contrast_stretch_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      operation,
	input  wire logic [lcs_pkg::PIX_W-1:0] pixel_in,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [lcs_pkg::PIX_W-1:0]      pixel_out,
	output logic                           last_of_frame,
	output logic                           flat_frame,
	output logic                           frame_truncated
);

	lcs_pkg::lcs_cmd_t  cmd;
	lcs_pkg::lcs_stat_t stat;

	// Controller
	lcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	// Datapath
	lcs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.pixel_in        (pixel_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_out       (pixel_out),
		.last_of_frame   (last_of_frame),
		.flat_frame      (flat_frame),
		.frame_truncated (frame_truncated)
	);

endmodule

`default_nettype wire

// ===== design/lcs_ctrl.sv =====
// Controller state machine for the linear contrast stretch unit.
// Depends on lcs_pkg for state, command and status types.
`default_nettype none

module lcs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              operation,
	input  wire lcs_pkg::lcs_stat_t stat,
	output lcs_pkg::lcs_cmd_t      cmd,
	output logic                   in_stall
);

	lcs_pkg::state_t state_q;
	lcs_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lcs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (operation == lcs_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (!stat.count_zero) begin
						// fetch the next stored pixel
						cmd.mem_rd = 1'b1;
						state_d    = lcs_pkg::ST_PREP;
					end
				end
			end
			lcs_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = lcs_pkg::ST_DIV;
			end
			lcs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = lcs_pkg::ST_DONE;
				end
			end
			lcs_pkg::ST_DONE: begin
				// hold until the output register can take the beat
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = lcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/lcs_datapath.sv =====
// Datapath: frame store, min/max trackers, restoring divider, output register.
// Depends on lcs_pkg for widths and command/status types.
`default_nettype none

module lcs_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lcs_pkg::lcs_cmd_t           cmd,
	output lcs_pkg::lcs_stat_t               stat,
	input  wire logic [lcs_pkg::PIX_W-1:0]   pixel_in,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [lcs_pkg::PIX_W-1:0]        pixel_out,
	output logic                             last_of_frame,
	output logic                             flat_frame,
	output logic                             frame_truncated
);

	localparam int PW = lcs_pkg::PIX_W;
	localparam int CW = lcs_pkg::CNT_W;
	localparam int AW = lcs_pkg::ADDR_W;

	logic [PW-1:0] store [lcs_pkg::MAX_PIXELS];
	logic [PW-1:0] rd_data_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] read_idx_q;
	logic [PW-1:0] min_q;
	logic [PW-1:0] max_q;
	logic          ovf_q;
	logic          out_valid_q;

	logic [PW-1:0]             rem_q;
	logic [PW-1:0]             low_q;
	logic [PW-1:0]             div_q;
	logic                      flat_q;
	logic [lcs_pkg::STEP_W-1:0] step_q;

	logic            load_ok;
	logic            store_full;
	logic            is_last;
	logic [PW-1:0]   num;
	logic [2*PW-1:0] dividend;
	logic [PW:0]     trial;
	logic            qbit;

	assign store_full = (count_q == CW'(lcs_pkg::MAX_PIXELS));
	assign load_ok    = cmd.load && (read_idx_q == '0) && !store_full;
	assign is_last    = ((read_idx_q + CW'(1)) == count_q);

	// num * 255 as (num << 8) - num
	assign num      = (rd_data_q >= min_q) ? (rd_data_q - min_q) : '0;
	assign dividend = {num, {PW{1'b0}}} - {{PW{1'b0}}, num};

	// one restoring divider step
	assign trial = {rem_q, low_q[PW-1]};
	assign qbit  = (trial >= {1'b0, div_q});

	assign stat.count_zero = (count_q == '0);
	assign stat.div_last   = (step_q == lcs_pkg::STEP_W'(lcs_pkg::QUO_BITS - 1));
	assign stat.out_busy   = out_valid_q && out_stall;

	// Frame store write and registered read
	always_ff @(posedge clk) begin
		if (load_ok) begin
			store[count_q[AW-1:0]] <= pixel_in;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= store[read_idx_q[AW-1:0]];
		end
	end

	// Frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			read_idx_q <= '0;
			min_q      <= '1;
			max_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.finish) begin
			if (is_last) begin
				count_q    <= '0;
				read_idx_q <= '0;
				min_q      <= '1;
				max_q      <= '0;
				ovf_q      <= 1'b0;
			end else begin
				read_idx_q <= read_idx_q + CW'(1);
			end
		end else if (cmd.load && (read_idx_q == '0)) begin
			if (store_full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
				if (pixel_in < min_q) begin
					min_q <= pixel_in;
				end
				if (pixel_in > max_q) begin
					max_q <= pixel_in;
				end
			end
		end
	end

	// Divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.prep) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + lcs_pkg::STEP_W'(1);
		end
	end

	// Divider datapath; quotient shifts into low_q
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q  <= dividend[2*PW-1:PW];
			low_q  <= dividend[PW-1:0];
			div_q  <= max_q - min_q;
			flat_q <= (max_q <= min_q);
		end else if (cmd.div_step) begin
			rem_q <= qbit ? PW'(trial - {1'b0, div_q}) : trial[PW-1:0];
			low_q <= {low_q[PW-2:0], qbit};
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pixel_out       <= flat_q ? '0 : low_q;
			last_of_frame   <= is_last;
			flat_frame      <= flat_q;
			frame_truncated <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sim/lcs_stretch_checker.sv =====
// Checker for the linear contrast stretch unit: watches both channels, keeps its
// own copy of the frame store and trackers, and compares every output beat.
// Depends on lcs_pkg.

module lcs_stretch_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      operation,
	input  logic [lcs_pkg::PIX_W-1:0] pixel_in,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [lcs_pkg::PIX_W-1:0] pixel_out,
	input  logic                      last_of_frame,
	input  logic                      flat_frame,
	input  logic                      frame_truncated,
	output int unsigned               fail_count,
	output int unsigned               pending_beats
);

	typedef struct packed {
		logic [lcs_pkg::PIX_W-1:0] level;
		logic                      last;
		logic                      flat;
		logic                      truncated;
	} stretched_t;

	// Predicted frame state
	logic [lcs_pkg::PIX_W-1:0] frame_copy [lcs_pkg::MAX_PIXELS];
	int unsigned      loaded_cnt;
	int unsigned      drained_cnt;
	int unsigned      lo_level;
	int unsigned      hi_level;
	logic             dropped_load;
	int unsigned      mismatches;
	stretched_t       stretched_q [$];

	task automatic clear_frame();
		loaded_cnt   = 0;
		drained_cnt  = 0;
		lo_level     = 255;
		hi_level     = 0;
		dropped_load = 1'b0;
	endtask

	// Apply one accepted input beat to the predicted state
	task automatic track_beat(input lcs_pkg::op_t op, input logic [lcs_pkg::PIX_W-1:0] px);
		stretched_t  want;
		int unsigned grey;
		if (op == lcs_pkg::OP_LOAD) begin
			// loads once draining has begun are ignored; loads into a full store are dropped
			if (drained_cnt != 0)
				return;
			if (loaded_cnt >= lcs_pkg::MAX_PIXELS) begin
				dropped_load = 1'b1;
				return;
			end
			frame_copy[loaded_cnt] = px;
			loaded_cnt++;
			if (px < lo_level)
				lo_level = px;
			if (px > hi_level)
				hi_level = px;
			return;
		end
		// drain of an empty store gives nothing
		if (loaded_cnt == 0 || drained_cnt >= loaded_cnt)
			return;
		grey = frame_copy[drained_cnt];
		want.flat      = (hi_level <= lo_level);
		want.level     = want.flat ? '0 :
			lcs_pkg::PIX_W'(((grey - lo_level) * 255) / (hi_level - lo_level));
		want.truncated = dropped_load;
		drained_cnt++;
		want.last      = (drained_cnt >= loaded_cnt);
		stretched_q.push_back(want);
		if (want.last)
			clear_frame();
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		stretched_t want;
		if (!arst_n) begin
			for (int i = 0; i < lcs_pkg::MAX_PIXELS; i++)
				frame_copy[i] = '0;
			clear_frame();
			stretched_q.delete();
			mismatches = 0;
			fail_count    <= 0;
			pending_beats <= 0;
		end else begin
			// output beat: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				if (stretched_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual pixel %0d last %0b flat %0b trunc %0b",
						$time, pixel_out, last_of_frame, flat_frame, frame_truncated);
					mismatches++;
				end else begin
					want = stretched_q.pop_front();
					check_field("pixel_out", want.level, pixel_out);
					check_field("last_of_frame", want.last, last_of_frame);
					check_field("flat_frame", want.flat, flat_frame);
					check_field("frame_truncated", want.truncated, frame_truncated);
				end
			end
			// input beat: advance the prediction
			if (in_valid && !in_stall)
				track_beat(lcs_pkg::op_t'(operation), pixel_in);
			fail_count    <= mismatches;
			pending_beats <= stretched_q.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the linear contrast stretch testbench: clock, reset, load/drain stimulus,
// receiver stalls, watchdog and verdict. Depends on lcs_pkg, the unit and
// lcs_stretch_checker.

module testbench;

	localparam int unsigned RANDOM_ITEMS  = 1500;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned DRAIN_LATENCY = 24;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic                      operation  = lcs_pkg::OP_LOAD;
	logic [lcs_pkg::PIX_W-1:0] pixel_in   = '0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic [lcs_pkg::PIX_W-1:0] pixel_out;
	logic                      last_of_frame;
	logic                      flat_frame;
	logic                      frame_truncated;
	int unsigned               fail_count;
	int unsigned               pending_beats;

	int unsigned idle_pct     = 24;
	bit          hold_req     = 1'b0;
	int unsigned random_items = 0;
	int unsigned quiet_cycles = 0;

	linear_contrast_stretch_unit dut (.*);

	lcs_stretch_checker checker_i (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Watchdog: no beat on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// One input beat, with random idle cycles ahead of it
	task automatic send_beat(input lcs_pkg::op_t op, input logic [lcs_pkg::PIX_W-1:0] px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		pixel_in  <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
	endtask

	// Well-formed frame: n loads in [lo, hi], then n drains; ignored loads and
	// empty drains sprinkled in as noise
	task automatic send_frame(input int unsigned n, input int unsigned lo, input int unsigned hi);
		for (int unsigned i = 0; i < n; i++)
			send_beat(lcs_pkg::OP_LOAD, lcs_pkg::PIX_W'(lo + $urandom_range(hi - lo)));
		for (int unsigned i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(99) < 4)
				send_beat(lcs_pkg::OP_LOAD, lcs_pkg::PIX_W'($urandom()));
			send_beat(lcs_pkg::OP_DRAIN, lcs_pkg::PIX_W'($urandom()));
		end
		if ($urandom_range(99) < 5)
			send_beat(lcs_pkg::OP_DRAIN, lcs_pkg::PIX_W'($urandom()));
		random_items += 2 * n;
	endtask

	initial begin
		int unsigned frame_no;
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Drain of an empty store
		send_beat(lcs_pkg::OP_DRAIN, 8'd0);
		// Extremes of grey level
		send_beat(lcs_pkg::OP_LOAD, 8'd0);
		send_beat(lcs_pkg::OP_LOAD, 8'd255);
		send_beat(lcs_pkg::OP_LOAD, 8'd128);
		send_beat(lcs_pkg::OP_LOAD, 8'd1);
		send_beat(lcs_pkg::OP_LOAD, 8'd254);
		repeat (5) send_beat(lcs_pkg::OP_DRAIN, 8'd255);
		// Load once draining has begun
		send_beat(lcs_pkg::OP_LOAD, 8'd10);
		send_beat(lcs_pkg::OP_LOAD, 8'd20);
		send_beat(lcs_pkg::OP_DRAIN, 8'd0);
		send_beat(lcs_pkg::OP_LOAD, 8'd99);
		send_beat(lcs_pkg::OP_DRAIN, 8'd0);
		// Flat frame
		repeat (3) send_beat(lcs_pkg::OP_LOAD, 8'd77);
		repeat (3) send_beat(lcs_pkg::OP_DRAIN, 8'd0);
		// Single-pixel frame, then a drain past its end
		send_beat(lcs_pkg::OP_LOAD, 8'd200);
		send_beat(lcs_pkg::OP_DRAIN, 8'd0);
		send_beat(lcs_pkg::OP_DRAIN, 8'd0);
		wait_drained();

		// Random frames
		frame_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			frame_no++;
			idle_pct = (frame_no >= 40 && frame_no < 70) ? 0 : 24;
			if (frame_no == 25 || frame_no == 90)
				wait_drained();
			lo = $urandom_range(255);
			hi = ($urandom_range(9) == 0) ? lo : $urandom_range(255, lo);
			n  = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
			pick = $urandom_range(99);
			// long receiver hold-off while a frame is in flight
			if (frame_no == 20) begin
				hold_req = 1'b1;
				n    = 32;
				pick = 0;
			end
			if (pick < 85) begin
				send_frame(n, lo, hi);
			end else begin
				// broken sequence: random operations and levels
				repeat ($urandom_range(8, 1)) begin
					send_beat(lcs_pkg::op_t'($urandom_range(1)), lcs_pkg::PIX_W'($urandom()));
					random_items++;
				end
			end
		end

		wait_drained();
		repeat (DRAIN_LATENCY) @(posedge clk);
		if (fail_count == 0 && pending_beats == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
design/lcs_pkg.sv
design/lcs_ctrl.sv
design/lcs_datapath.sv
design/linear_contrast_stretch_unit.sv
sim/lcs_stretch_checker.sv
sim/testbench.sv
